@@ hdl/fcs_pkg.sv @@
// Shared types and codes for the FIFO with content statistics.
package fcs_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_OUT_W = 5;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP = 2'd1;
	localparam logic [1:0] ACT_REPORT = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic signed [VALUE_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [VALUE_W-1:0] popped_value;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic signed [VALUE_W-1:0] largest;
		logic signed [VALUE_W-1:0] smallest;
		logic signed [VALUE_W-1:0] mean_value;
	} rsp_t;

endpackage

@@ hdl/fcs_stream_if.sv @@
// Valid/ready channel interface that carries one payload per transfer.
interface fcs_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/fcs_ram.sv @@
// Entry storage: one write port and one registered read port.
module fcs_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = 4
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [31:0] wr_data,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output logic [31:0] rd_data
);
	logic [31:0] entry_q [DEPTH];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= entry_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

@@ hdl/fcs_divider.sv @@
// Iterative restoring divider: signed dividend by positive count, one bit per cycle.
module fcs_divider #(
	parameter int unsigned DW = 37,
	parameter int unsigned VW = 5
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DW-1:0] dividend,
	input logic [VW-1:0] divisor,
	output logic done,
	output logic [31:0] quotient
);
	localparam int unsigned NW = $clog2(DW + 1);

	logic busy_q;
	logic done_q;
	logic [NW-1:0] step_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] den_q;
	logic [DW-1:0] quo_q;
	logic neg_q;

	logic [VW:0] trial;
	logic [VW:0] diff;
	logic fits;
	logic [DW-1:0] mag;
	logic [DW-1:0] quo_signed;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};
	assign mag = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
	assign quo_signed = neg_q ? (~quo_q + DW'(1)) : quo_q;
	assign quotient = quo_signed[31:0];
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= NW'(DW);
			end else if (busy_q) begin
				step_q <= step_q - NW'(1);
				if (step_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[DW-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end
endmodule

@@ hdl/fifo_with_content_statistics.sv @@
// From the command transfer to a valid result: a scan that reads each held entry in turn, a
// drain of the last read, one bit per cycle in the divider, then result loading, which waits
// while rsp.ready holds off an earlier result. An empty queue skips the division. Throughput:
// one command at a time; cmd.ready is high only while idle, so no new command is taken before
// the previous result is loaded.
// Reset (arst_n, asynchronous, active low) empties the queue; entry storage is not cleared.
module fifo_with_content_statistics #(
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	fcs_stream_if.sink cmd,
	fcs_stream_if.source rsp
);
	import fcs_pkg::*;

	// Index, count and sum widths. The sum holds DEPTH values of 32 bits without overflow.
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = VALUE_W + CW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_DIV_GO = 5'b00100,
		S_DIV_WAIT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] scan_idx_q;
	logic [CW-1:0] issue_q;
	logic rd_vld_s1;
	logic pop_s1;
	logic first_q;
	logic rsp_valid_q;

	logic signed [VALUE_W-1:0] big_q;
	logic signed [VALUE_W-1:0] small_q;
	logic signed [SW-1:0] sum_q;
	logic signed [VALUE_W-1:0] popped_q;
	logic signed [VALUE_W-1:0] mean_q;
	logic [1:0] status_q;
	rsp_t rsp_q;

	logic accept;
	logic do_push;
	logic do_pop;
	logic scan_issue;
	logic scan_end;
	logic rsp_load;
	logic ram_wr_en;
	logic ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic [31:0] ram_rd_data;
	logic signed [VALUE_W-1:0] scan_val;
	logic div_start;
	logic div_done;
	logic [31:0] div_quotient;
	logic [AW-1:0] head_next;
	logic [AW-1:0] tail_next;
	logic [AW-1:0] scan_idx_next;

	// Ring pointers wrap at DEPTH, which need not be a power of two.
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_next = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign scan_idx_next = (scan_idx_q == AW'(DEPTH - 1)) ? '0 : scan_idx_q + AW'(1);

	assign cmd.ready = (state_q == S_IDLE);
	assign accept = cmd.valid && cmd.ready;
	assign do_push = (cmd.data.action == ACT_PUSH) && (count_q != CW'(DEPTH));
	assign do_pop = (cmd.data.action == ACT_POP) && (count_q != '0);

	// The scan issues one read per cycle; its data comes back in the following cycle.
	assign scan_issue = (state_q == S_SCAN) && (issue_q != count_q);
	assign scan_end = (state_q == S_SCAN) && (issue_q == count_q) && !rd_vld_s1;
	assign scan_val = ram_rd_data;

	// The pop read shares the read port with the scan; it is issued at the command transfer.
	assign ram_wr_en = accept && do_push;
	assign ram_rd_en = (accept && do_pop) || scan_issue;
	assign ram_rd_addr = (state_q == S_IDLE) ? head_q : scan_idx_q;

	assign div_start = (state_q == S_DIV_GO);
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	fcs_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(ram_wr_en),
		.wr_addr(tail_q),
		.wr_data(cmd.data.push_value),
		.rd_en(ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	fcs_divider #(
		.DW(SW),
		.VW(CW)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(sum_q),
		.divisor(count_q),
		.done(div_done),
		.quotient(div_quotient)
	);

	// Sequencer and queue bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			scan_idx_q <= '0;
			issue_q <= '0;
			rd_vld_s1 <= 1'b0;
			pop_s1 <= 1'b0;
			first_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pop_s1 <= do_pop;
						first_q <= 1'b1;
						issue_q <= '0;
						if (do_push) begin
							tail_q <= tail_next;
							count_q <= count_q + CW'(1);
						end
						if (do_pop) begin
							head_q <= head_next;
							scan_idx_q <= head_next;
							count_q <= count_q - CW'(1);
						end else begin
							scan_idx_q <= head_q;
						end
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pop_s1 <= 1'b0;
					if (scan_issue) begin
						issue_q <= issue_q + CW'(1);
						scan_idx_q <= scan_idx_next;
					end
					if (rd_vld_s1) begin
						first_q <= 1'b0;
					end
					if (scan_end) begin
						// An empty queue needs no division; the mean is zero.
						state_q <= (count_q == '0) ? S_DONE : S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Statistics datapath: one compare pair and one adder, used once per held entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			big_q <= '0;
			small_q <= '0;
			sum_q <= '0;
			popped_q <= '0;
			mean_q <= '0;
			if ((cmd.data.action == ACT_PUSH) && !do_push) begin
				status_q <= ST_FULL;
			end else if ((cmd.data.action == ACT_POP) && !do_pop) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
			end
		end
		if (pop_s1) begin
			popped_q <= ram_rd_data;
		end
		if (rd_vld_s1) begin
			if (first_q) begin
				big_q <= scan_val;
				small_q <= scan_val;
				sum_q <= SW'(scan_val);
			end else begin
				if (scan_val > big_q) begin
					big_q <= scan_val;
				end
				if (scan_val < small_q) begin
					small_q <= scan_val;
				end
				sum_q <= sum_q + SW'(scan_val);
			end
		end
		if ((state_q == S_DIV_WAIT) && div_done) begin
			mean_q <= div_quotient;
		end
		if (rsp_load) begin
			rsp_q.status <= status_q;
			rsp_q.popped_value <= popped_q;
			rsp_q.entry_count <= COUNT_OUT_W'(count_q);
			rsp_q.largest <= big_q;
			rsp_q.smallest <= small_q;
			rsp_q.mean_value <= mean_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;
endmodule

@@ hdl/fcs_checker.sv @@
// Port-level assertions for the FIFO with content statistics, and their bind.
module fcs_checker #(
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] status,
	input logic [31:0] popped_value,
	input logic [4:0] entry_count,
	input logic [31:0] largest,
	input logic [31:0] smallest,
	input logic [31:0] mean_value
);
	import fcs_pkg::*;

	// A result that is not taken stays offered unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(mean_value) && $stable(status))
	else $error("result changed while stalled");

	// The mean always lies between the smallest and the largest held value.
	a_mean_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ($signed(smallest) <= $signed(mean_value))
			&& ($signed(mean_value) <= $signed(largest)))
	else $error("mean outside min/max range");

	// An empty queue reports zero statistics.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(DEPTH < 32) && rsp_valid && (entry_count == 5'd0)
			|-> (largest == 32'd0) && (smallest == 32'd0) && (mean_value == 32'd0))
	else $error("empty queue with nonzero statistics");

	// Only a completed pop can return a value.
	a_popped_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (popped_value != 32'd0) |-> (status == ST_DONE))
	else $error("popped value on a refused operation");

	// A full queue that refuses a push holds every slot.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(DEPTH < 32) && rsp_valid && (status == ST_FULL) |-> (entry_count == 5'(DEPTH)))
	else $error("push refused while not full");
endmodule

bind fifo_with_content_statistics fcs_checker #(
	.DEPTH(DEPTH)
) u_fcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.data.status),
	.popped_value(rsp.data.popped_value),
	.entry_count(rsp.data.entry_count),
	.largest(rsp.data.largest),
	.smallest(rsp.data.smallest),
	.mean_value(rsp.data.mean_value)
);

@@ dv/fifo_with_content_statistics_test.sv @@
// Self-checking testbench for the FIFO with content statistics: directed and random traffic.
`timescale 1ns / 100ps

module fifo_with_content_statistics_test;
	import fcs_pkg::*;

	localparam int unsigned QDEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 1150;
	localparam int REPORT_LIMIT = 10;
	localparam int DRAIN_CYCLES = 100;

	// Action code 3 is not one of the named codes; the block treats it as a report.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fcs_stream_if #(.T(cmd_t)) cmd_ch ();
	fcs_stream_if #(.T(rsp_t)) rsp_ch ();

	fifo_with_content_statistics #(
		.DEPTH(QDEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// Free-running 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the queue: a ring of slots with head, tail and fill level.
	logic signed [VALUE_W-1:0] shadow_slots [QDEPTH];
	int unsigned shadow_head;
	int unsigned shadow_tail;
	int unsigned shadow_fill;

	// Statistics expected for every accepted command, oldest first.
	rsp_t expected_stats [$];

	// When set, neither side inserts idle cycles; used for back-to-back stretches.
	bit calm;
	int stall_left;
	int mismatches;
	int unsigned cycles;

	// Applies one command to the shadow queue and returns the result it should give.
	function automatic rsp_t fifo_stats_after(input logic [1:0] act,
			input logic signed [VALUE_W-1:0] val);
		rsp_t r;
		longint total;
		int unsigned idx;
		r = '0;
		r.status = ST_DONE;
		if (act == ACT_PUSH) begin
			if (shadow_fill >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_slots[shadow_tail] = val;
				shadow_tail = (shadow_tail + 1) % QDEPTH;
				shadow_fill++;
			end
		end else if (act == ACT_POP) begin
			if (shadow_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.popped_value = shadow_slots[shadow_head];
				shadow_head = (shadow_head + 1) % QDEPTH;
				shadow_fill--;
			end
		end
		r.entry_count = shadow_fill[COUNT_OUT_W-1:0];
		// Max, min and mean cover only the held entries; an empty queue reads all zero.
		if (shadow_fill > 0) begin
			idx = shadow_head;
			total = 0;
			r.largest = shadow_slots[idx];
			r.smallest = shadow_slots[idx];
			for (int unsigned k = 0; k < shadow_fill; k++) begin
				if (shadow_slots[idx] > r.largest)
					r.largest = shadow_slots[idx];
				if (shadow_slots[idx] < r.smallest)
					r.smallest = shadow_slots[idx];
				total += longint'(shadow_slots[idx]);
				idx = (idx + 1) % QDEPTH;
			end
			// The sum is 64 bits wide, so it cannot wrap; signed division truncates toward zero.
			r.mean_value = 32'(total / longint'(shadow_fill));
		end
		return r;
	endfunction

	// Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Values favor the extremes and small numbers near zero, where truncation of a
	// negative mean shows up, next to fully random words that toggle every bit.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				return VAL_MAX;
			end
			1: begin
				return VAL_MIN;
			end
			2, 3, 4: begin
				return VALUE_W'($urandom_range(0, 10) - 5);
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// Mode 0 fills the queue, mode 1 drains it, mode 2 keeps it level, mode 3 raises the share of reports.
	function automatic logic [1:0] pick_action(input int mode);
		int r;
		int push_pct;
		int pop_pct;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				push_pct = 70;
				pop_pct = 23;
			end
			1: begin
				push_pct = 25;
				pop_pct = 65;
			end
			2: begin
				push_pct = 46;
				pop_pct = 46;
			end
			default: begin
				push_pct = 30;
				pop_pct = 30;
			end
		endcase
		if (r < 2)
			return ACT_SPARE;
		if (r < 2 + push_pct)
			return ACT_PUSH;
		if (r < 2 + push_pct + pop_pct)
			return ACT_POP;
		return ACT_REPORT;
	endfunction

	// Drives one command and returns at the rising edge where it is transferred.
	// Valid is left high so that a following command with no gap goes out back to back;
	// it is lowered only at a falling edge where no new command is raised.
	task automatic send_cmd(input logic [1:0] act, input logic signed [VALUE_W-1:0] val);
		int gap;
		cmd_t item;
		gap = pick_gap();
		item.action = act;
		item.push_value = val;
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= item;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		// The transfer happened at this edge, so the shadow queue moves now.
		expected_stats.push_back(fifo_stats_after(act, val));
	endtask

	// Holds off until every outstanding result has been checked. Valid is dropped first
	// so the last command is not offered a second time while the sender waits.
	task automatic wait_until_drained();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected: status=%0d popped=%0d count=%0d max=%0d min=%0d mean=%0d",
				want.status, want.popped_value, want.entry_count, want.largest,
				want.smallest, want.mean_value);
			$display("  actual:   status=%0d popped=%0d count=%0d max=%0d min=%0d mean=%0d",
				got.status, got.popped_value, got.entry_count, got.largest,
				got.smallest, got.mean_value);
		end
	endtask

	// Result sink: ready drops for random stretches, set up at the falling edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// Every result transfer is checked against the oldest expectation, all fields at once;
	// the report shows each field so a wrong one is easy to spot.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("result transfer with nothing outstanding", '0, rsp_ch.data);
			end else begin
				if (rsp_ch.data !== expected_stats[0])
					report_mismatch("result mismatch", expected_stats[0], rsp_ch.data);
				void'(expected_stats.pop_front());
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("fifo_with_content_statistics_test: done, errors");
			$finish;
		end
	end

	// An empty queue: report, pop refused, and the spare action code all read zero statistics.
	task automatic test_empty_queue();
		send_cmd(ACT_REPORT, 32'sd0);
		send_cmd(ACT_POP, 32'sd17);
		send_cmd(ACT_SPARE, VAL_MAX);
	endtask

	// Extreme values side by side. Max plus min sums to -1, whose mean truncates to 0;
	// adding -2 gives a sum of -3 over three entries, a mean of exactly -1.
	task automatic test_extremes_and_mean();
		send_cmd(ACT_PUSH, VAL_MAX);
		send_cmd(ACT_PUSH, VAL_MIN);
		send_cmd(ACT_REPORT, 32'sd0);
		send_cmd(ACT_PUSH, -32'sd2);
		send_cmd(ACT_SPARE, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
	endtask

	// Fill to the last slot with the largest value so the sum grows well past 32 bits,
	// then a push that must be refused, then one pop to leave the full state.
	task automatic test_full_queue();
		while (shadow_fill < QDEPTH)
			send_cmd(ACT_PUSH, VAL_MAX);
		send_cmd(ACT_PUSH, 32'sd5);
		send_cmd(ACT_POP, 32'sd0);
	endtask

	// Bursts of random commands, each burst biased toward filling, draining, holding
	// level or reporting, so the queue swings between empty and full many times. Some
	// bursts run with no idle cycles on either side. Halfway through, the sender stops
	// until every result is back, so the block also sees a fully idle restart.
	task automatic test_random_traffic();
		int sent;
		int mode;
		int run;
		bit paused;
		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			run = $urandom_range(10, 60);
			calm = ($urandom_range(0, 4) == 0);
			repeat (run) begin
				send_cmd(pick_action(mode), pick_value());
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_until_drained();
				paused = 1'b1;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rsp_ch.ready = 1'b0;
		shadow_head = 0;
		shadow_tail = 0;
		shadow_fill = 0;
		calm = 1'b0;
		stall_left = 0;
		mismatches = 0;
		cycles = 0;

		// Reset once, released away from the rising edge.
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_extremes_and_mean();
		test_full_queue();
		test_random_traffic();

		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		// Let the last results arrive, then watch a while longer for stray transfers.
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("fifo_with_content_statistics_test: done, clean");
		end else begin
			$display("fifo_with_content_statistics_test: done, errors");
		end
		$finish;
	end

endmodule
